// ===== rtl/assert_macros.svh =====
// Assertion macros included by des_salted_password_hash.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== rtl/dsph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsph_pkg
// DES tables, permutation functions and the per-slot payload type.
// ----------------------------------------------------------------------------
package dsph_pkg;

    localparam int NUM_ROUNDS = 16;

    localparam logic [6:0] CH_UPPER_Z = 7'd90;
    localparam logic [6:0] CH_NINE    = 7'd57;
    localparam logic [6:0] CH_DOT     = 7'd46;

    typedef struct packed {
        logic [31:0] l;
        logic [31:0] r;
        logic [27:0] c;
        logic [27:0] d;
        logic [11:0] salt;
    } t_blk;

    localparam int FP_TAB [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };

    localparam int PC1_TAB [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4 };

    localparam int PC2_TAB [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32 };

    localparam int E_TAB [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1 };

    localparam int P_TAB [32] = '{
        16,7,20,21, 29,12,28,17, 1,15,23,26, 5,18,31,10,
        2,8,24,14, 32,27,3,9, 19,13,30,6, 22,11,4,25 };

    localparam int ROT_TAB [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    localparam int SBOX [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,5,6,3,11} };

    function automatic logic [63:0] f_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-FP_TAB[i]];
        return r;
    endfunction

    function automatic logic [55:0] f_pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64-PC1_TAB[i]];
        return r;
    endfunction

    function automatic logic [47:0] f_pc2(input logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56-PC2_TAB[i]];
        return r;
    endfunction

    function automatic logic [47:0] f_expand(input logic [31:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[32-E_TAB[i]];
        return r;
    endfunction

    function automatic logic [31:0] f_perm_p(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) r[31-i] = v[32-P_TAB[i]];
        return r;
    endfunction

    function automatic logic [27:0] f_rot28(input logic [27:0] v, input int n);
        logic [27:0] r;
        if (n == 1) begin
            r = {v[26:0], v[27]};
        end else begin
            r = {v[25:0], v[27:26]};
        end
        return r;
    endfunction

    function automatic logic [5:0] f_salt_decode(input logic [6:0] ch);
        logic [6:0] v;
        v = ch;
        if (v > CH_UPPER_Z) v = v - 7'd6;
        if (v > CH_NINE) v = v - 7'd7;
        v = v - CH_DOT;
        return v[5:0];
    endfunction

    function automatic logic [31:0] f_round(input logic [31:0] r, input logic [47:0] subkey,
                                            input logic [11:0] salt);
        logic [47:0] e;
        logic [23:0] mask;
        logic [23:0] t;
        logic [5:0]  six;
        logic [5:0]  idx;
        logic [31:0] s;
        for (int k = 0; k < 12; k++) mask[23-k] = salt[k];
        mask[11:0] = 12'd0;
        e = f_expand(r);
        t = (e[47:24] ^ e[23:0]) & mask;
        e = e ^ {t, t} ^ subkey;
        for (int b = 0; b < 8; b++) begin
            six = e[47-6*b -: 6];
            idx = {six[5], six[0], six[4:1]};
            s[31-4*b -: 4] = 4'(SBOX[b][idx]);
        end
        return f_perm_p(s);
    endfunction

endpackage

// ===== rtl/dsph_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsph_prep
// Build the DES key halves and the salt bits for a new transaction.
// ----------------------------------------------------------------------------
module dsph_prep (
    input  logic [55:0]         i_key_chars,
    input  logic [6:0]          i_salt_first,
    input  logic [6:0]          i_salt_second,
    output dsph_pkg::t_blk      o_blk
);

    logic [63:0] key;
    logic [55:0] cd;
    logic [6:0]  ch;
    logic        ended;

    always_comb begin
        ended = 1'b0;
        key   = 64'd0;
        for (int i = 0; i < 8; i++) begin
            ch = i_key_chars[55-7*i -: 7];
            if (ch == 7'd0) ended = 1'b1;
            if (ended) ch = 7'd0;
            key[63-8*i -: 8] = {ch, 1'b0};
        end
    end

    assign cd         = dsph_pkg::f_pc1(key);
    assign o_blk.l    = 32'd0;
    assign o_blk.r    = 32'd0;
    assign o_blk.c    = cd[55:28];
    assign o_blk.d    = cd[27:0];
    assign o_blk.salt = {dsph_pkg::f_salt_decode(i_salt_second),
                         dsph_pkg::f_salt_decode(i_salt_first)};

endmodule

// ===== rtl/dsph_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsph_stage
// One registered DES round with its own key-schedule rotation.
// ----------------------------------------------------------------------------
module dsph_stage #(
    parameter int ROUND = 0,
    parameter int PW    = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [PW-1:0]       i_pass,
    input  dsph_pkg::t_blk      i_blk,
    output logic                o_valid,
    output logic [PW-1:0]       o_pass,
    output dsph_pkg::t_blk      o_blk
);

    logic           r_valid;
    logic [PW-1:0]  r_pass;
    dsph_pkg::t_blk r_blk;
    dsph_pkg::t_blk n_blk;
    logic [47:0]    subkey;

    always_comb begin
        n_blk      = i_blk;
        n_blk.c    = dsph_pkg::f_rot28(i_blk.c, dsph_pkg::ROT_TAB[ROUND]);
        n_blk.d    = dsph_pkg::f_rot28(i_blk.d, dsph_pkg::ROT_TAB[ROUND]);
        subkey     = dsph_pkg::f_pc2({n_blk.c, n_blk.d});
        n_blk.l    = i_blk.r;
        n_blk.r    = i_blk.l ^ dsph_pkg::f_round(i_blk.r, subkey, i_blk.salt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pass <= i_pass;
            r_blk  <= n_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_pass  = r_pass;
    assign o_blk   = r_blk;

endmodule

// ===== rtl/des_salted_password_hash.sv =====
// Each accepted transaction passes the 16-stage round ring ITERATION_COUNT times and its
// hash is then registered for o_valid; output stalls delay it. The round ring holds
// up to 16 transactions, so new ones can enter while earlier ones are still in flight.
// A new transaction enters only in a cycle when the ring's entry slot is free.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_salted_password_hash
// Salted, repeated DES password hash on a recirculating round pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module des_salted_password_hash #(
    parameter int ITERATION_COUNT = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [55:0] i_key_chars,
    input  logic [6:0]  i_salt_first,
    input  logic [6:0]  i_salt_second,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_hash_block
);

    localparam int PW = (ITERATION_COUNT > 1) ? $clog2(ITERATION_COUNT) : 1;
    localparam int NR = dsph_pkg::NUM_ROUNDS;

    logic           w_valid [0:NR];
    logic [PW-1:0]  w_pass  [0:NR];
    dsph_pkg::t_blk w_blk   [0:NR];
    dsph_pkg::t_blk new_blk;
    dsph_pkg::t_blk loop_blk;

    logic        fin;
    logic        recirc;
    logic        out_load;
    logic        blocked;
    logic        accept;
    logic        r_out_valid;
    logic [63:0] r_hash;

    dsph_prep u_prep (
        .i_key_chars   (i_key_chars),
        .i_salt_first  (i_salt_first),
        .i_salt_second (i_salt_second),
        .o_blk         (new_blk)
    );

    assign fin      = w_valid[NR] && (w_pass[NR] == PW'(ITERATION_COUNT - 1));
    assign recirc   = w_valid[NR] && !fin;
    assign out_load = fin && (!r_out_valid || !i_stall);
    assign blocked  = fin && !out_load;
    assign o_stall  = blocked || recirc;
    assign accept   = i_valid && !o_stall;

    always_comb begin
        loop_blk   = w_blk[NR];
        loop_blk.l = w_blk[NR].r;
        loop_blk.r = w_blk[NR].l;
    end

    assign w_valid[0] = recirc || accept;
    assign w_pass[0]  = recirc ? w_pass[NR] + PW'(1) : '0;
    assign w_blk[0]   = recirc ? loop_blk : new_blk;

    for (genvar g = 0; g < NR; g++) begin : g_round
        dsph_stage #(
            .ROUND (g),
            .PW    (PW)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (!blocked),
            .i_valid (w_valid[g]),
            .i_pass  (w_pass[g]),
            .i_blk   (w_blk[g]),
            .o_valid (w_valid[g+1]),
            .o_pass  (w_pass[g+1]),
            .o_blk   (w_blk[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_hash <= dsph_pkg::f_fp({w_blk[NR].r, w_blk[NR].l});
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hash_block = r_hash;

    `ASSERT_CLK(a_load_shows, i_clk, i_rst_n, out_load |=> r_out_valid)
    `ASSERT_CLK(a_freeze_holds, i_clk, i_rst_n,
                blocked |=> (w_valid[NR] && $stable(w_blk[NR]) && $stable(w_pass[NR])))
    `ASSERT_NEVER(a_no_entry_clash, i_clk, i_rst_n, accept && w_valid[NR] && !fin)

endmodule
